### rtl/cbt_pkg.sv
// shared widths, command and status codes and control types for the barrier table
`timescale 1ns / 1ps

package cbt_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned ID_W     = 4;
  localparam int unsigned PART_W   = 8;
  localparam int unsigned ST_W     = 2;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned ID_REACH = 16;

  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ARRIVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_BADID = 2'd2;

  typedef struct packed {
    logic load_in;
    logic exec;
  } cbt_dp_cmd_t;

endpackage

### rtl/cbt_if.sv
// request and response channel interfaces of the barrier table
`timescale 1ns / 1ps

interface cbt_req_if import cbt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ID_W-1:0]   barrier_id;
  logic [PART_W-1:0] participants;

  modport source (output valid, cmd, barrier_id, participants, input ready);
  modport sink (input valid, cmd, barrier_id, participants, output ready);
endinterface

interface cbt_rsp_if import cbt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [ID_W-1:0]  granted_id;
  logic             release_res;
  logic [CNT_W-1:0] arrivals;

  modport source (output valid, status, granted_id, release_res, arrivals, input ready);
  modport sink (input valid, status, granted_id, release_res, arrivals, output ready);
endinterface

### rtl/cbt_ctrl.sv
// barrier table controller: capture and execute sequencing, result handshake
`timescale 1ns / 1ps

module cbt_ctrl import cbt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output cbt_dp_cmd_t dp_cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free         = !out_valid_q || out_ready_i;
  assign in_ready_o       = (state_q == S_IDLE);
  assign dp_cmd_o.load_in = in_valid_i && (state_q == S_IDLE);
  assign dp_cmd_o.exec    = (state_q == S_EXEC) && out_free;
  assign out_valid_o      = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (dp_cmd_o.load_in) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (dp_cmd_o.exec) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (dp_cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/cbt_dp.sv
// barrier table datapath: entry table, free-entry search, count update, result register
`timescale 1ns / 1ps

module cbt_dp import cbt_pkg::*; #(
  parameter int unsigned USABLE = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cbt_dp_cmd_t       dp_cmd_i,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [ID_W-1:0]   barrier_id_i,
  input  logic [PART_W-1:0] participants_i,
  output logic [ST_W-1:0]   status_o,
  output logic [ID_W-1:0]   granted_id_o,
  output logic              release_res_o,
  output logic [CNT_W-1:0]  arrivals_o
);

  localparam int unsigned IDX_W = $clog2(USABLE);

  logic [CMD_W-1:0]  cmd_q;
  logic [ID_W-1:0]   id_q;
  logic [PART_W-1:0] parts_q;

  logic [USABLE-1:0] in_use_q;
  logic [CNT_W-1:0]  count_q [USABLE];

  logic [ST_W-1:0]  status_q, status_d;
  logic [ID_W-1:0]  granted_q, granted_d;
  logic             release_q, release_d;
  logic [CNT_W-1:0] arrivals_q, arrivals_d;

  logic [IDX_W-1:0] sel_idx;
  logic             in_range;
  logic             sel_used;
  logic [IDX_W-1:0] free_idx;
  logic             found;
  logic [CNT_W-1:0] cnt_cur;
  logic [CNT_W-1:0] cnt_sat;
  logic             done;
  logic [CNT_W-1:0] cnt_next;

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load_in) begin
      cmd_q   <= cmd_i;
      id_q    <= barrier_id_i;
      parts_q <= participants_i;
    end
  end

  assign sel_idx  = id_q[IDX_W-1:0];
  assign in_range = (ID_W+1)'(id_q) < (ID_W+1)'(USABLE);
  assign sel_used = in_range && in_use_q[sel_idx];

  // lowest-numbered free entry
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = USABLE - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        found    = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign cnt_cur  = count_q[sel_idx];
  assign cnt_sat  = (cnt_cur == '1) ? cnt_cur : cnt_cur + CNT_W'(1);
  assign done     = (cnt_sat >= parts_q);
  assign cnt_next = done ? '0 : cnt_sat;

  always_comb begin
    status_d   = ST_BADID;
    granted_d  = '0;
    release_d  = 1'b0;
    arrivals_d = '0;
    case (cmd_q)
      CMD_ALLOC: begin
        if (found) begin
          status_d  = ST_OK;
          granted_d = ID_W'(free_idx);
        end else begin
          status_d  = ST_FULL;
        end
      end
      CMD_ARRIVE: begin
        if (sel_used) begin
          status_d   = ST_OK;
          release_d  = done;
          arrivals_d = cnt_next;
        end
      end
      CMD_FREE: begin
        if (sel_used) status_d = ST_OK;
      end
      default: status_d = ST_BADID;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      count_q  <= '{default: '0};
    end else if (dp_cmd_i.exec) begin
      case (cmd_q)
        CMD_ALLOC: begin
          if (found) begin
            in_use_q[free_idx] <= 1'b1;
            count_q[free_idx]  <= '0;
          end
        end
        CMD_ARRIVE: begin
          if (sel_used) count_q[sel_idx] <= cnt_next;
        end
        CMD_FREE: begin
          if (sel_used) begin
            in_use_q[sel_idx] <= 1'b0;
            count_q[sel_idx]  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.exec) begin
      status_q   <= status_d;
      granted_q  <= granted_d;
      release_q  <= release_d;
      arrivals_q <= arrivals_d;
    end
  end

  assign status_o      = status_q;
  assign granted_id_o  = granted_q;
  assign release_res_o = release_q;
  assign arrivals_o    = arrivals_q;

  // a released barrier always reports a cleared count
  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_i.exec |=> (!release_q || arrivals_q == '0))
    else $error("release reported with nonzero count");

  // table full is only reported when every entry is in use
  a_full_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_i.exec |=> (status_q != ST_FULL || &in_use_q))
    else $error("full status with a free entry");

  // a granted entry is marked in use
  a_alloc_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_cmd_i.exec && cmd_q == CMD_ALLOC && found) |=> in_use_q[$past(free_idx)])
    else $error("allocated entry not marked in use");

  // a freed entry is released to the pool
  a_free_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_cmd_i.exec && cmd_q == CMD_FREE && sel_used) |=> !in_use_q[$past(sel_idx)])
    else $error("freed entry still in use");

endmodule

### rtl/counting_barrier_table.sv
// counting barrier table top level: controller, datapath and channel hookup
// result: registered in the execute step after its request item is captured
// ordering: a new item is taken only after the last one executes; the capture
//   and execute steps alternate; execution waits while a result is not taken
// reset: asynchronous, clears the whole table at once so every entry is free
//   with a zero count; no clearing pass, requests are taken right after reset
`timescale 1ns / 1ps

module counting_barrier_table import cbt_pkg::*; #(
  parameter int unsigned NUM_BARRIERS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cbt_req_if.sink   req_i,
  cbt_rsp_if.source rsp_o
);

  localparam int unsigned USABLE = (NUM_BARRIERS < ID_REACH) ? NUM_BARRIERS : ID_REACH;

  cbt_dp_cmd_t dp_cmd;

  cbt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .dp_cmd_o    (dp_cmd)
  );

  cbt_dp #(
    .USABLE (USABLE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .dp_cmd_i       (dp_cmd),
    .cmd_i          (req_i.cmd),
    .barrier_id_i   (req_i.barrier_id),
    .participants_i (req_i.participants),
    .status_o       (rsp_o.status),
    .granted_id_o   (rsp_o.granted_id),
    .release_res_o  (rsp_o.release_res),
    .arrivals_o     (rsp_o.arrivals)
  );

endmodule

### bench/counting_barrier_table_tb.sv
// self-checking testbench for the counting barrier table: directed and random command items
`timescale 1ns / 1ps

module counting_barrier_table_tb;
  import cbt_pkg::*;

  localparam int unsigned NUM_BARRIERS = 16;
  localparam int unsigned USABLE = (NUM_BARRIERS < ID_REACH) ? NUM_BARRIERS : ID_REACH;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [ID_W-1:0]  granted_id;
    logic             release_res;
    logic [CNT_W-1:0] arrivals;
  } barrier_rsp_t;

  logic clk_i;
  logic rst_ni;

  cbt_req_if req ();
  cbt_rsp_if rsp ();

  counting_barrier_table #(
    .NUM_BARRIERS(NUM_BARRIERS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  logic             slot_used  [ID_REACH];
  logic [CNT_W-1:0] slot_count [ID_REACH];
  barrier_rsp_t     pending_rsp_q[$];

  int unsigned n_errors;
  int unsigned quiet_cycles;
  int unsigned hold_req;
  int unsigned hold_left;
  int unsigned stall_left;
  bit          idle_on;

  barrier_rsp_t got_rsp;
  barrier_rsp_t exp_rsp;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic barrier_rsp_t predict_barrier_step(logic [CMD_W-1:0] cmd,
                                                       logic [ID_W-1:0] id,
                                                       logic [PART_W-1:0] parts);
    barrier_rsp_t r;
    bit           id_valid;
    logic [CNT_W-1:0] cnt;
    r = '0;
    r.status = ST_BADID;
    id_valid = (id < USABLE) && slot_used[id];
    if (cmd == CMD_ALLOC) begin
      r.status = ST_FULL;
      for (int i = 0; i < USABLE; i++) begin
        if (!slot_used[i] && r.status != ST_OK) begin
          slot_used[i] = 1'b1;
          slot_count[i] = '0;
          r.granted_id = i[ID_W-1:0];
          r.status = ST_OK;
        end
      end
    end else if (cmd == CMD_ARRIVE) begin
      if (id_valid) begin
        cnt = slot_count[id];
        if (cnt != 8'hff) cnt = cnt + CNT_W'(1);
        if (cnt >= parts) begin
          cnt = '0;
          r.release_res = 1'b1;
        end
        slot_count[id] = cnt;
        r.arrivals = cnt;
        r.status = ST_OK;
      end
    end else if (cmd == CMD_FREE) begin
      if (id_valid) begin
        slot_used[id] = 1'b0;
        slot_count[id] = '0;
        r.status = ST_OK;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
    n_errors++;
  endtask

  // response checker, request predictor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles = quiet_cycles + 1;
      if (rsp.valid && rsp.ready) begin
        quiet_cycles = 0;
        got_rsp = '{rsp.status, rsp.granted_id, rsp.release_res, rsp.arrivals};
        if (pending_rsp_q.size() == 0) begin
          report_mismatch("unexpected result", 32'(got_rsp), 0);
        end else begin
          exp_rsp = pending_rsp_q.pop_front();
          if (got_rsp.status !== exp_rsp.status)
            report_mismatch("status", 32'(got_rsp.status), 32'(exp_rsp.status));
          if (got_rsp.granted_id !== exp_rsp.granted_id)
            report_mismatch("granted_id", 32'(got_rsp.granted_id),
                            32'(exp_rsp.granted_id));
          if (got_rsp.release_res !== exp_rsp.release_res)
            report_mismatch("release_res", 32'(got_rsp.release_res),
                            32'(exp_rsp.release_res));
          if (got_rsp.arrivals !== exp_rsp.arrivals)
            report_mismatch("arrivals", 32'(got_rsp.arrivals), 32'(exp_rsp.arrivals));
        end
      end
      if (req.valid && req.ready) begin
        quiet_cycles = 0;
        pending_rsp_q.push_back(predict_barrier_step(req.cmd, req.barrier_id,
                                                     req.participants));
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no item accepted for %0d cycles", quiet_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // response side ready with random stall bursts and a requested long hold-off
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      rsp.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  task automatic send_item(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                           logic [PART_W-1:0] parts);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    req.valid        <= 1'b1;
    req.cmd          <= cmd;
    req.barrier_id   <= id;
    req.participants <= parts;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_empty_table();
    send_item(CMD_ARRIVE, 4'd0, 8'd1);
    send_item(CMD_FREE, 4'd15, 8'd255);
    send_item(CMD_UNUSED, 4'd7, 8'd3);
  endtask

  task automatic test_fill_table();
    for (int i = 0; i < USABLE; i++) send_item(CMD_ALLOC, 4'($urandom), 8'($urandom));
    send_item(CMD_ALLOC, 4'd0, 8'd0);
  endtask

  task automatic test_arrive_release();
    send_item(CMD_ARRIVE, 4'd0, 8'd3);
    send_item(CMD_ARRIVE, 4'd0, 8'd3);
    send_item(CMD_ARRIVE, 4'd0, 8'd3);
    send_item(CMD_ARRIVE, 4'd1, 8'd0);
    send_item(CMD_ARRIVE, 4'd1, 8'd1);
    send_item(CMD_ARRIVE, 4'd15, 8'd255);
    send_item(CMD_ARRIVE, 4'd15, 8'd2);
    send_item(CMD_UNUSED, 4'd15, 8'd0);
  endtask

  task automatic test_free_reuse();
    send_item(CMD_ARRIVE, 4'd3, 8'd9);
    send_item(CMD_FREE, 4'd3, 8'd0);
    send_item(CMD_ARRIVE, 4'd3, 8'd9);
    send_item(CMD_FREE, 4'd3, 8'd0);
    send_item(CMD_FREE, 4'd15, 8'd0);
    send_item(CMD_ALLOC, 4'd0, 8'd0);
    send_item(CMD_ALLOC, 4'd0, 8'd0);
    send_item(CMD_ARRIVE, 4'd3, 8'd1);
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_req = HOLD_CYCLES;
    for (int i = 0; i < 30; i++) send_item(CMD_ARRIVE, 4'($urandom_range(0, 15)),
                                           8'($urandom_range(0, 4)));
  endtask

  task automatic test_random(int unsigned n_items, int unsigned calm_tail);
    int unsigned n_used;
    int unsigned pick;
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   id;
    logic [PART_W-1:0] parts;
    for (int n = 0; n < n_items; n++) begin
      if (n + calm_tail >= n_items) idle_on = 1'b0;
      else if (n % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
      n_used = 0;
      for (int i = 0; i < USABLE; i++) n_used += 32'(slot_used[i]);
      pick = $urandom_range(0, 99);
      if (pick < 4) cmd = CMD_UNUSED;
      else if (pick < ((n_used > 12) ? 12 : 28)) cmd = CMD_ALLOC;
      else if (pick < ((n_used > 12) ? 40 : 38)) cmd = CMD_FREE;
      else cmd = CMD_ARRIVE;
      id = 4'($urandom);
      if (n_used != 0 && $urandom_range(0, 9) < 8) begin
        while (!slot_used[id] || id >= USABLE) id = 4'($urandom_range(0, USABLE - 1));
      end
      pick = $urandom_range(0, 19);
      if (pick == 0) parts = '0;
      else if (pick < 3) parts = 8'($urandom);
      else parts = 8'($urandom_range(1, 6));
      send_item(cmd, id, parts);
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    req.valid        = 1'b0;
    req.cmd          = CMD_ALLOC;
    req.barrier_id   = '0;
    req.participants = '0;
    rsp.ready        = 1'b0;
    n_errors         = 0;
    quiet_cycles     = 0;
    hold_req         = 0;
    hold_left        = 0;
    stall_left       = 0;
    idle_on          = 1'b1;
    for (int i = 0; i < ID_REACH; i++) begin
      slot_used[i]  = 1'b0;
      slot_count[i] = '0;
    end
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_table();
    test_fill_table();
    test_arrive_release();
    test_free_reuse();
    test_backpressure();
    idle_on = 1'b1;
    test_random(1400, 200);

    req.valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
